[src/pchm_pkg.sv]
// ----------------------------------------------------------------------------
// pchm_pkg - shared types and constants for the height map binning block
// Grid geometry, request codes, register indexes and bus layouts.
// ----------------------------------------------------------------------------
package pchm_pkg;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int NCELLS    = GRID_ROWS * GRID_COLS;
  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ADDR_W    = $clog2(NCELLS);

  localparam int COORD_W   = 32;
  localparam int RC_W      = 6;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 80;

  // request codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_X_MIN     = 3'd0;
  localparam logic [2:0] REG_X_MAX     = 3'd1;
  localparam logic [2:0] REG_Y_MIN     = 3'd2;
  localparam logic [2:0] REG_Y_MAX     = 3'd3;
  localparam logic [2:0] REG_Z_MIN     = 3'd4;
  localparam logic [2:0] REG_Z_MAX     = 3'd5;
  localparam logic [2:0] REG_COL_SCALE = 3'd6;
  localparam logic [2:0] REG_ROW_SCALE = 3'd7;

  localparam logic signed [31:0] X_MIN_RST = -32'sd65536;
  localparam logic signed [31:0] X_MAX_RST = 32'sd65536;
  localparam logic signed [31:0] Y_MIN_RST = -32'sd65536;
  localparam logic signed [31:0] Y_MAX_RST = 32'sd65536;
  localparam logic signed [31:0] Z_MIN_RST = 32'sd0;
  localparam logic signed [31:0] Z_MAX_RST = 32'sd131072;
  localparam logic [31:0]        SCALE_RST = 32'd2064384;

  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] x_max;
    logic signed [31:0] y_min;
    logic signed [31:0] y_max;
    logic signed [31:0] z_min;
    logic signed [31:0] z_max;
    logic        [31:0] col_scale;
    logic        [31:0] row_scale;
  } cfg_regs_t;

  // binning result of one point
  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } bin_res_t;

  // cell memory word: valid flag over height
  typedef struct packed {
    logic               vld;
    logic signed [31:0] height;
  } cell_word_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    cell_word_t        wr_data;
  } mem_req_t;

endpackage

[src/pchm_bin_index.sv]
// ----------------------------------------------------------------------------
// pchm_bin_index - bounds check and cell index of one point
// Stage one checks the open intervals and forms the offsets, stage two
// multiplies by the scales and checks the grid limits.
// ----------------------------------------------------------------------------
module pchm_bin_index
  import pchm_pkg::*;
(
  input  logic               clk,
  input  logic               stage1_en,
  input  logic               stage2_en,
  input  logic               is_add,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  cfg_regs_t          cfg,
  output bin_res_t           bin
);

  logic        range_ok_nxt, range_ok_r;
  logic [32:0] dx_full, dz_full;
  logic [31:0] dx_r, dz_r;
  logic [63:0] prod_x, prod_z;
  logic [31:0] col_full, row_full;
  bin_res_t    bin_nxt, bin_r;

  always_comb begin
    range_ok_nxt = is_add &&
                   (pos_x > cfg.x_min) && (pos_x < cfg.x_max) &&
                   (pos_y > cfg.y_min) && (pos_y < cfg.y_max) &&
                   (pos_z > cfg.z_min) && (pos_z < cfg.z_max);
    dx_full = {pos_x[31], pos_x} - {cfg.x_min[31], cfg.x_min};
    dz_full = {pos_z[31], pos_z} - {cfg.z_min[31], cfg.z_min};
  end

  always_ff @(posedge clk) begin
    if (stage1_en) begin
      range_ok_r <= range_ok_nxt;
      dx_r       <= dx_full[31:0];
      dz_r       <= dz_full[31:0];
    end
  end

  always_comb begin
    prod_x   = 64'(dx_r) * 64'(cfg.col_scale);
    prod_z   = 64'(dz_r) * 64'(cfg.row_scale);
    col_full = prod_x[63:32];
    row_full = prod_z[63:32];
    bin_nxt.hit = range_ok_r && (col_full < 32'(GRID_COLS)) && (row_full < 32'(GRID_ROWS));
    bin_nxt.col = col_full[COL_W-1:0];
    bin_nxt.row = row_full[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (stage2_en) begin
      bin_r <= bin_nxt;
    end
  end

  assign bin = bin_r;

endmodule

[src/pchm_cell_mem.sv]
// ----------------------------------------------------------------------------
// pchm_cell_mem - cell height store
// One write and one registered read per cycle, one entry per grid cell.
// ----------------------------------------------------------------------------
module pchm_cell_mem
  import pchm_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output cell_word_t rd_data
);

  cell_word_t cells [NCELLS];
  cell_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      cells[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= cells[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/point_cloud_height_map_binning_top.sv]
// ----------------------------------------------------------------------------
// point_cloud_height_map_binning_top - max height grid of a point stream
//
//   channel | direction | tdata (low bit up)                  | tuser
//   in_     | request   | pos_x, pos_y, pos_z, read_row, col  | action
//   out_    | result    | cell_row, cell_col, height, floor   | accepted
//   cfg_    | write     | cfg_wr_data at register cfg_index   | -
//
// A request holds the block through capture, offsets, scale multiply, cell
// memory read and write-back; its result is registered at write-back.
// A clear adds a pass over all 4096 cells of the cell memory, and reset starts the
// same pass; in_tready stays low throughout. A stalled result holds in the
// output register while the next request is taken; write-back waits for it.
// ----------------------------------------------------------------------------
module point_cloud_height_map_binning_top
  import pchm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], read_row[101:96], read_col[107:102]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]            in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cell_row[5:0], cell_col[11:6], cell_height[43:12], floor_ht[75:44]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // accepted[0]
  output logic [0:0]            out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_wr_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUB  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   sweep_r, sweep_nxt;
  cfg_regs_t           cfg_r;
  logic signed [31:0]  floor_r, floor_nxt;

  logic [1:0]          act_r;
  logic signed [31:0]  px_r, py_r, pz_r;
  logic [RC_W-1:0]     rrow_r, rcol_r;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                out_acc_r, out_acc_nxt;

  bin_res_t            bin;
  mem_req_t            mem_req;
  cell_word_t          mem_rd;

  logic                in_fire, emit;
  logic                read_in_grid;
  logic [ADDR_W-1:0]   bin_addr, read_addr;
  logic signed [31:0]  h_nxt;
  logic [RC_W-1:0]     res_row, res_col;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min     <= X_MIN_RST;
      cfg_r.x_max     <= X_MAX_RST;
      cfg_r.y_min     <= Y_MIN_RST;
      cfg_r.y_max     <= Y_MAX_RST;
      cfg_r.z_min     <= Z_MIN_RST;
      cfg_r.z_max     <= Z_MAX_RST;
      cfg_r.col_scale <= SCALE_RST;
      cfg_r.row_scale <= SCALE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_X_MIN:     cfg_r.x_min     <= cfg_wr_data;
        REG_X_MAX:     cfg_r.x_max     <= cfg_wr_data;
        REG_Y_MIN:     cfg_r.y_min     <= cfg_wr_data;
        REG_Y_MAX:     cfg_r.y_max     <= cfg_wr_data;
        REG_Z_MIN:     cfg_r.z_min     <= cfg_wr_data;
        REG_Z_MAX:     cfg_r.z_max     <= cfg_wr_data;
        REG_COL_SCALE: cfg_r.col_scale <= cfg_wr_data;
        REG_ROW_SCALE: cfg_r.row_scale <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_tuser;
      px_r   <= in_tdata[31:0];
      py_r   <= in_tdata[63:32];
      pz_r   <= in_tdata[95:64];
      rrow_r <= in_tdata[101:96];
      rcol_r <= in_tdata[107:102];
    end
  end

  pchm_bin_index u_bin_index (
    .clk       (clk),
    .stage1_en (state_r == ST_SUB),
    .stage2_en (state_r == ST_MUL),
    .is_add    (act_r == ACT_ADD),
    .pos_x     (px_r),
    .pos_y     (py_r),
    .pos_z     (pz_r),
    .cfg       (cfg_r),
    .bin       (bin)
  );

  pchm_cell_mem u_cell_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  always_comb begin
    bin_addr     = ADDR_W'(bin.row) * ADDR_W'(GRID_COLS) + ADDR_W'(bin.col);
    read_addr    = ADDR_W'(rrow_r) * ADDR_W'(GRID_COLS) + ADDR_W'(rcol_r);
    read_in_grid = (32'(rrow_r) < 32'(GRID_ROWS)) && (32'(rcol_r) < 32'(GRID_COLS));
    emit         = (state_r == ST_WB) && (!out_valid_r || out_tready);
  end

  // write-back: merge the cell, update the floor, form the result
  always_comb begin
    floor_nxt = floor_r;
    out_acc_nxt = 1'b0;
    res_row = '0;
    res_col = '0;
    h_nxt   = py_r;
    mem_req = '0;

    if (state_r == ST_RD) begin
      mem_req.rd_en   = 1'b1;
      mem_req.rd_addr = (act_r == ACT_READ) ? read_addr : bin_addr;
    end

    case (act_r)
      ACT_CLEAR: begin
        h_nxt     = cfg_r.y_min;
        floor_nxt = emit ? cfg_r.z_max : floor_r;
      end
      ACT_READ: begin
        res_row = rrow_r;
        res_col = rcol_r;
        h_nxt   = (read_in_grid && mem_rd.vld) ? mem_rd.height : cfg_r.y_min;
      end
      ACT_ADD: begin
        if (bin.hit) begin
          out_acc_nxt = 1'b1;
          res_row = RC_W'(bin.row);
          res_col = RC_W'(bin.col);
          h_nxt   = (mem_rd.vld && (mem_rd.height > py_r)) ? mem_rd.height : py_r;
          if (emit) begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = bin_addr;
            mem_req.wr_data.vld    = 1'b1;
            mem_req.wr_data.height = h_nxt;
            if (h_nxt < floor_r) begin
              floor_nxt = h_nxt;
            end
          end
        end else begin
          h_nxt = '0;
        end
      end
      default: begin
        h_nxt = '0;
      end
    endcase

    if (state_r == ST_CLR) begin
      mem_req.wr_en          = 1'b1;
      mem_req.wr_addr        = sweep_r;
      mem_req.wr_data.vld    = 1'b0;
      mem_req.wr_data.height = '0;
    end

    out_data_nxt = {4'b0, floor_nxt, h_nxt, res_col, res_row};
  end

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WB;
      ST_WB: begin
        if (emit) begin
          state_nxt = (act_r == ACT_CLEAR) ? ST_CLR : ST_IDLE;
          sweep_nxt = '0;
        end
      end
      ST_CLR: begin
        sweep_nxt = sweep_r + ADDR_W'(1);
        if (sweep_r == ADDR_W'(NCELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      sweep_r     <= '0;
      floor_r     <= Z_MAX_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      floor_r     <= floor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result payload until the new one is emitted
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
      out_acc_r  <= out_acc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_acc_r;

endmodule

[src/pchm_checker.sv]
// ----------------------------------------------------------------------------
// pchm_checker - port-level checks of the height map binning block
// Bound to the top level; watches the request and result channels.
// ----------------------------------------------------------------------------
module pchm_checker
  import pchm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic [1:0]            in_tuser,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]            out_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  // one request in flight: no back-to-back acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // a clear starts the memory sweep, so no request is taken for a while
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == ACT_CLEAR) |=> ##5 !in_tready)
    else $error("request taken during clear sweep");

  // a binned point never leaves the floor above its cell
  a_floor_below_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      ($signed(out_tdata[75:44]) <= $signed(out_tdata[43:12])))
    else $error("floor above updated cell height");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind point_cloud_height_map_binning_top pchm_checker u_pchm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - height map binning block, self-checking stream bench
// Drives add, clear, read and no-op requests through the input stream and
// predicts every result with a behavioral copy of the grid, the floor and
// the register set. Starts with a short directed list, then runs random
// traffic over several register settings with random sender bursts and
// receiver stalls, checking each result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pchm_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic signed [31:0] ONE   = 32'sd65536;
  localparam logic signed [31:0] TWO   = 32'sd131072;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [5:0]         read_row;
    logic [5:0]         read_col;
  } point_req_t;

  typedef struct packed {
    logic               accepted;
    logic [5:0]         cell_row;
    logic [5:0]         cell_col;
    logic signed [31:0] cell_height;
    logic signed [31:0] floor_ht;
  } bin_result_t;

  typedef struct packed {
    point_req_t  req;
    logic        typed;
    bin_result_t want;
  } directed_row_t;

  localparam bin_result_t PREDICTED = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = ACT_ADD;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [2:0]            cfg_index = REG_X_MIN;
  logic [31:0]           cfg_wr_data = '0;

  point_cloud_height_map_binning_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predicted grid state and register copy
  cfg_regs_t          active_cfg = '{X_MIN_RST, X_MAX_RST, Y_MIN_RST, Y_MAX_RST,
                                     Z_MIN_RST, Z_MAX_RST, SCALE_RST, SCALE_RST};
  logic signed [31:0] cell_heights [NCELLS];
  bit                 cell_valid [NCELLS];
  logic signed [31:0] floor_level = Z_MAX_RST;

  bin_result_t   pending_cells [$];
  directed_row_t directed_rows [$];
  point_req_t    last_point;
  logic [5:0]    last_row = '0;
  logic [5:0]    last_col = '0;

  int burst_left = 0;
  int fail_count = 0;
  int n_requests = 0;
  int n_binned = 0;
  int n_dropped = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_checked = 0;
  int n_settings = 1;
  int quiet_cycles = 0;

  function automatic bin_result_t bin_request(point_req_t r);
    bin_result_t        res;
    longint unsigned    dx;
    longint unsigned    dz;
    longint unsigned    col;
    longint unsigned    row;
    int                 k;
    logic signed [31:0] h;
    res = '0;
    res.floor_ht = floor_level;
    case (r.action)
      ACT_CLEAR: begin
        foreach (cell_valid[i]) cell_valid[i] = 1'b0;
        floor_level = active_cfg.z_max;
        res.cell_height = active_cfg.y_min;
        res.floor_ht = floor_level;
      end
      ACT_READ: begin
        res.cell_row = r.read_row;
        res.cell_col = r.read_col;
        k = int'(r.read_row) * GRID_COLS + int'(r.read_col);
        res.cell_height = cell_valid[k] ? cell_heights[k] : active_cfg.y_min;
      end
      ACT_ADD: begin
        if ($signed(r.pos_x) > $signed(active_cfg.x_min) &&
            $signed(r.pos_x) < $signed(active_cfg.x_max) &&
            $signed(r.pos_y) > $signed(active_cfg.y_min) &&
            $signed(r.pos_y) < $signed(active_cfg.y_max) &&
            $signed(r.pos_z) > $signed(active_cfg.z_min) &&
            $signed(r.pos_z) < $signed(active_cfg.z_max)) begin
          dx  = longint'($signed(r.pos_x)) - longint'($signed(active_cfg.x_min));
          dz  = longint'($signed(r.pos_z)) - longint'($signed(active_cfg.z_min));
          col = (dx * longint'({32'd0, active_cfg.col_scale})) >> 32;
          row = (dz * longint'({32'd0, active_cfg.row_scale})) >> 32;
          if (col < GRID_COLS && row < GRID_ROWS) begin
            k = int'(row) * GRID_COLS + int'(col);
            h = r.pos_y;
            if (cell_valid[k] && cell_heights[k] > h) h = cell_heights[k];
            cell_heights[k] = h;
            cell_valid[k] = 1'b1;
            if (h < floor_level) floor_level = h;
            res.accepted = 1'b1;
            res.cell_row = row[5:0];
            res.cell_col = col[5:0];
            res.cell_height = h;
            res.floor_ht = floor_level;
            last_row = row[5:0];
            last_col = col[5:0];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic point_req_t mk_req(logic [1:0] a, logic signed [31:0] x, y, z,
                                        logic [5:0] rr, rc);
    point_req_t r;
    r = '{a, x, y, z, rr, rc};
    return r;
  endfunction

  function automatic bin_result_t mk_result(logic acc, logic [5:0] row, col,
                                            logic signed [31:0] h, f);
    bin_result_t res;
    res = '{acc, row, col, h, f};
    return res;
  endfunction

  // append one row to the directed table
  function automatic void add_row(directed_row_t d);
    directed_rows.insert(directed_rows.size(), d);
  endfunction

  // uniform value strictly between lo and hi; any value if the gap is empty
  function automatic logic [31:0] pick_inside(logic signed [31:0] lo, hi);
    longint          span;
    longint unsigned rnd;
    span = longint'(hi) - longint'(lo);
    if (span < 2) return $urandom;
    rnd = {$urandom, $urandom};
    return 32'(longint'(lo) + 1 + longint'(rnd % longint'(span - 1)));
  endfunction

  function automatic point_req_t make_item();
    point_req_t r;
    int         pick;
    r.action   = ACT_ADD;
    r.pos_x    = $urandom;
    r.pos_y    = $urandom;
    r.pos_z    = $urandom;
    r.read_row = 6'($urandom);
    r.read_col = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      r.pos_x = pick_inside(active_cfg.x_min, active_cfg.x_max);
      r.pos_y = pick_inside(active_cfg.y_min, active_cfg.y_max);
      r.pos_z = pick_inside(active_cfg.z_min, active_cfg.z_max);
      if (pick >= 60 && pick < 70) begin
        // hit the previous point's cell again with a new height
        r.pos_x = last_point.pos_x;
        r.pos_z = last_point.pos_z;
      end else if (pick >= 76) begin
        case ($urandom_range(0, 5))
          0: r.pos_x = active_cfg.x_min;
          1: r.pos_x = active_cfg.x_max;
          2: r.pos_y = active_cfg.y_min;
          3: r.pos_y = active_cfg.y_max;
          4: r.pos_z = active_cfg.z_min;
          default: r.pos_z = active_cfg.z_max;
        endcase
      end
      if (pick < 70) last_point = r;
      if (pick >= 70 && pick < 76) begin
        r.pos_x = $urandom;
        r.pos_y = $urandom;
        r.pos_z = $urandom;
      end
    end else if (pick < 95) begin
      r.action = ACT_READ;
      if ($urandom_range(0, 1) == 0) begin
        r.read_row = last_row;
        r.read_col = last_col;
      end
    end else if (pick < 99) begin
      r.action = ACT_NONE;
    end else begin
      r.action = ACT_CLEAR;
    end
    return r;
  endfunction

  function automatic void random_axis(output logic signed [31:0] lo, hi,
                                      output logic [31:0] scale);
    longint          span;
    longint unsigned s;
    lo   = $signed($urandom) >>> 1;
    span = $urandom_range(2, 32'h0010_0000);
    hi   = 32'(longint'(lo) + span);
    // spread about 72 cells over the span so the far end falls off the grid
    s = (longint'(72) << 32) / span;
    scale = (s > 64'hffff_ffff) ? 32'hffff_ffff : s[31:0];
  endfunction

  task automatic send_request(point_req_t r, logic typed, bin_result_t want);
    bin_result_t predicted;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tdata  <= {4'b0, r.read_col, r.read_row, r.pos_z, r.pos_y, r.pos_x};
    in_tuser  <= r.action;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = bin_request(r);
    pending_cells.insert(pending_cells.size(), typed ? want : predicted);
    n_requests++;
    case (r.action)
      ACT_READ:  n_reads++;
      ACT_CLEAR: n_clears++;
      default: begin
        if (predicted.accepted) n_binned++;
        else n_dropped++;
      end
    endcase
    burst_left--;
    @(negedge clk);
  endtask

  // hold the sender until every pending result is back and any clear pass
  // is over, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_cells.size() != 0) @(negedge clk);
    while (!in_tready) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_settings(cfg_regs_t s);
    logic [2:0] idx;
    drain();
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_X_MIN:     cfg_wr_data <= s.x_min;
        REG_X_MAX:     cfg_wr_data <= s.x_max;
        REG_Y_MIN:     cfg_wr_data <= s.y_min;
        REG_Y_MAX:     cfg_wr_data <= s.y_max;
        REG_Z_MIN:     cfg_wr_data <= s.z_min;
        REG_Z_MAX:     cfg_wr_data <= s.z_max;
        REG_COL_SCALE: cfg_wr_data <= s.col_scale;
        default:       cfg_wr_data <= s.row_scale;
      endcase
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    active_cfg = s;
    n_settings++;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      send_request(make_item(), 1'b0, PREDICTED);
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    bin_result_t got;
    bin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[5:0], out_tdata[11:6], out_tdata[43:12],
             out_tdata[75:44]};
      n_checked++;
      if (pending_cells.size() == 0) begin
        $error("result with no request pending: tdata 0x%h tuser %0d", out_tdata,
               out_tuser);
        fail_count++;
      end else begin
        want = pending_cells.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(got.accepted));
        check_field("cell_row", 32'(want.cell_row), 32'(got.cell_row));
        check_field("cell_col", 32'(want.cell_col), 32'(got.cell_col));
        check_field("cell_height", want.cell_height, got.cell_height);
        check_field("floor_ht", want.floor_ht, got.floor_ht);
      end
    end
  end

  // receiver: switch at random between stall styles
  int stall_mode = 0;
  int stall_mode_left = 0;
  int stall_hold = 0;

  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_mode_left <= $urandom_range(50, 300);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 9) != 0);
      default: begin
        if (stall_hold == 0) begin
          out_tready <= ~out_tready;
          stall_hold <= $urandom_range(1, 8);
        end else begin
          stall_hold <= stall_hold - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no request or result moved for %0d cycles, %0d results pending",
             quiet_cycles, pending_cells.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cfg_regs_t s;
    // empty-cell reads and dropped points right after reset
    add_row({mk_req(ACT_READ, 0, 0, 0, 0, 0), 1'b1,
             mk_result(0, 0, 0, -ONE, TWO)});
    add_row({mk_req(ACT_READ, 0, 0, 0, 63, 63), 1'b1,
             mk_result(0, 63, 63, -ONE, TWO)});
    add_row({mk_req(ACT_ADD, -ONE, 0, ONE, 0, 0), 1'b1,
             mk_result(0, 0, 0, 0, TWO)});
    add_row({mk_req(ACT_ADD, ONE, 0, ONE, 0, 0), 1'b1,
             mk_result(0, 0, 0, 0, TWO)});
    add_row({mk_req(ACT_ADD, 0, -ONE, ONE, 0, 0), 1'b1,
             mk_result(0, 0, 0, 0, TWO)});
    add_row({mk_req(ACT_ADD, 0, ONE, ONE, 0, 0), 1'b1,
             mk_result(0, 0, 0, 0, TWO)});
    add_row({mk_req(ACT_ADD, 0, 0, 0, 0, 0), 1'b1,
             mk_result(0, 0, 0, 0, TWO)});
    add_row({mk_req(ACT_ADD, 0, 0, TWO, 0, 0), 1'b1,
             mk_result(0, 0, 0, 0, TWO)});
    add_row({mk_req(ACT_ADD, MIN32, 0, ONE, 0, 0), 1'b1,
             mk_result(0, 0, 0, 0, TWO)});
    add_row({mk_req(ACT_ADD, MAX32, MIN32, MAX32, 0, 0), 1'b1,
             mk_result(0, 0, 0, 0, TWO)});
    add_row({mk_req(ACT_NONE, 0, 0, ONE, 63, 63), 1'b1,
             mk_result(0, 0, 0, 0, TWO)});
    // binned points: corners, same cell lower, higher, back to back
    add_row({mk_req(ACT_ADD, 0, 0, ONE, 0, 0), 1'b0, PREDICTED});
    add_row({mk_req(ACT_ADD, -ONE + 1, -ONE + 1, 1, 0, 0), 1'b0, PREDICTED});
    add_row({mk_req(ACT_ADD, ONE - 1, ONE - 1, TWO - 1, 0, 0), 1'b0, PREDICTED});
    add_row({mk_req(ACT_ADD, 0, -100, ONE, 0, 0), 1'b0, PREDICTED});
    add_row({mk_req(ACT_ADD, 0, 300, ONE, 0, 0), 1'b0, PREDICTED});
    add_row({mk_req(ACT_ADD, 0, 200, ONE + 100, 0, 0), 1'b0, PREDICTED});
    add_row({mk_req(ACT_READ, 0, 0, 0, 31, 31), 1'b0, PREDICTED});
    add_row({mk_req(ACT_READ, 0, 0, 0, 0, 0), 1'b0, PREDICTED});
    // clear, then the grid reads empty and the floor is back at z_max
    add_row({mk_req(ACT_CLEAR, MAX32, MAX32, MAX32, 63, 63), 1'b1,
             mk_result(0, 0, 0, -ONE, TWO)});
    add_row({mk_req(ACT_READ, 0, 0, 0, 31, 31), 1'b1,
             mk_result(0, 31, 31, -ONE, TWO)});
    add_row({mk_req(ACT_ADD, 0, 5, ONE, 0, 0), 1'b0, PREDICTED});
    add_row({mk_req(ACT_READ, 0, 0, 0, 31, 31), 1'b0, PREDICTED});
    last_point = mk_req(ACT_ADD, 0, 0, ONE, 0, 0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    run_random(300);

    // full signed range on every bound; floor carries over without a clear
    s.x_min = MIN32;
    s.x_max = MAX32;
    s.y_min = MIN32;
    s.y_max = MAX32;
    s.z_min = MIN32;
    s.z_max = MAX32;
    s.col_scale = 32'd63;
    s.row_scale = 32'd64;
    write_settings(s);
    run_random(400);

    // largest column scale on a narrow x span, every point in row 0
    s.x_min = 32'sd0;
    s.x_max = 32'sd65;
    s.y_min = -32'sd1000;
    s.y_max = 32'sd1000;
    s.z_min = -32'sd5;
    s.z_max = 32'sd5;
    s.col_scale = 32'hffff_ffff;
    s.row_scale = 32'd0;
    write_settings(s);
    send_request(mk_req(ACT_CLEAR, 0, 0, 0, 0, 0), 1'b0, PREDICTED);
    run_random(350);

    repeat (2) begin
      random_axis(s.x_min, s.x_max, s.col_scale);
      random_axis(s.z_min, s.z_max, s.row_scale);
      s.y_min = $signed($urandom) >>> 2;
      s.y_max = s.y_min + $urandom_range(2, 32'h1000_0000);
      write_settings(s);
      send_request(mk_req(ACT_CLEAR, 0, 0, 0, 0, 0), 1'b0, PREDICTED);
      run_random(280);
    end

    in_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests over %0d register settings: %0d points binned, %0d dropped",
             n_requests, n_settings, n_binned, n_dropped);
    $display("with %0d cell reads and %0d grid clears; %0d results checked, %0d errors",
             n_reads, n_clears, n_checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
